// ===== rtl/iir_direct_form_two_filter_core_macros.svh =====
// Assertion macros shared by the biquad RTL
`ifndef IIR_DIRECT_FORM_TWO_FILTER_CORE_MACROS_SVH
`define IIR_DIRECT_FORM_TWO_FILTER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define IIR_DF2_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("iir_df2 assertion failed");
`define IIR_DF2_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("iir_df2 forbidden condition seen");
`else
`define IIR_DF2_ASSERT(name, clk, rst_n, prop)
`define IIR_DF2_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

// ===== rtl/iir_df2_pkg.sv =====
// Types and constants of the direct form II biquad
`default_nettype none

package iir_df2_pkg;

  localparam int unsigned DATA_W   = 16;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 5;
  localparam int unsigned REG_IDXW = 3;

  // Register map, index = paddr / 4
  localparam logic [REG_IDXW-1:0] REG_FB1 = 3'd0;
  localparam logic [REG_IDXW-1:0] REG_FB2 = 3'd1;
  localparam logic [REG_IDXW-1:0] REG_FF0 = 3'd2;
  localparam logic [REG_IDXW-1:0] REG_FF1 = 3'd3;
  localparam logic [REG_IDXW-1:0] REG_FF2 = 3'd4;

  typedef struct packed {
    logic [DATA_W-1:0] fb1;
    logic [DATA_W-1:0] fb2;
    logic [DATA_W-1:0] ff0;
    logic [DATA_W-1:0] ff1;
    logic [DATA_W-1:0] ff2;
  } coef_t;

  typedef struct packed {
    logic              start;
    logic              sub;
    logic              load;
    logic [DATA_W-1:0] base;
  } mac_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mac_sts_t;

endpackage

`default_nettype wire

// ===== rtl/iir_df2_ifs.sv =====
// Valid/ready channel interfaces for input and output samples
`default_nettype none

interface iir_df2_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [iir_df2_pkg::DATA_W-1:0]   sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface iir_df2_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [iir_df2_pkg::DATA_W-1:0]   sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/iir_direct_form_two_filter_core.sv =====
// Direct form II biquad IIR filter, top level
//
// Input samples arrive on src_i and filtered samples leave on res_o, both
// valid/ready channels; an item moves when valid and ready are both high.
// The five coefficients sit in APB registers at byte addresses 0, 4, 8, 12
// and 16 (a1, a2, b0, b1, b2); write them only while the filter is idle.
// All arithmetic wraps to 16 bits.
// Every product goes through one digit-serial multiply-accumulate unit that
// takes DIGIT_W multiplier bits per cycle. An item needs P products (5 for a
// second order filter, 3 for first order), and no new item is taken until
// the current one has finished its final step.
// src_i.ready is high whenever no item is in work, even if the last result
// is still waiting on res_o; a stalled output holds its result and the next
// item then waits in its final step until the output register frees up.
// Reset clears the coefficients and the delay line to zero.
`default_nettype none
`include "iir_direct_form_two_filter_core_macros.svh"

module iir_direct_form_two_filter_core #(
  parameter int unsigned FILTER_ORDER = 2,
  parameter int unsigned DIGIT_W      = 4
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  iir_df2_in_if.sink                             src_i,
  iir_df2_out_if.source                          res_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [iir_df2_pkg::APB_AW-1:0]    paddr,
  input  wire logic [iir_df2_pkg::APB_DW-1:0]    pwdata,
  output logic      [iir_df2_pkg::APB_DW-1:0]    prdata,
  output logic                                   pready
);

  localparam int unsigned DataW  = iir_df2_pkg::DATA_W;
  localparam bit          Order2 = (FILTER_ORDER == 2);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_FB1  = 7'b0000010,
    ST_FB2  = 7'b0000100,
    ST_FF0  = 7'b0001000,
    ST_FF1  = 7'b0010000,
    ST_FF2  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  state_e                  state_q, state_d;
  iir_df2_pkg::coef_t      coef;
  iir_df2_pkg::mac_cmd_t   mac_cmd;
  iir_df2_pkg::mac_sts_t   mac_sts;
  logic [DataW-1:0]        mac_coef;
  logic [DataW-1:0]        mac_operand;
  logic [DataW-1:0]        acc;

  logic [DataW-1:0]        d1_q, d2_q;
  logic [DataW-1:0]        w_q;
  logic [DataW-1:0]        out_q;
  logic                    out_valid_q;
  logic                    w_en;
  logic                    out_load;
  logic                    in_accept;

  iir_df2_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef)
  );

  iir_df2_mac #(
    .DIGIT_W (DIGIT_W)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (mac_cmd),
    .coef_i    (mac_coef),
    .operand_i (mac_operand),
    .sts_o     (mac_sts),
    .acc_o     (acc)
  );

  assign src_i.ready = (state_q == ST_IDLE);
  assign in_accept   = src_i.valid & src_i.ready;

  // sequencer: w = x - a1*d1 - a2*d2, then y = b0*w + b1*d1 + b2*d2 (a2, b2 terms in second order only)
  always_comb begin
    state_d     = state_q;
    mac_cmd     = '0;
    mac_coef    = coef.fb1;
    mac_operand = d1_q;
    w_en        = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          mac_cmd.start = 1'b1;
          mac_cmd.sub   = 1'b1;
          mac_cmd.load  = 1'b1;
          mac_cmd.base  = src_i.sample_in;
          state_d       = ST_FB1;
        end
      end
      ST_FB1: begin
        if (mac_sts.done) begin
          mac_cmd.start = 1'b1;
          if (Order2) begin
            mac_cmd.sub = 1'b1;
            mac_coef    = coef.fb2;
            mac_operand = d2_q;
            state_d     = ST_FB2;
          end else begin
            mac_cmd.load = 1'b1;
            mac_coef     = coef.ff0;
            mac_operand  = acc;
            w_en         = 1'b1;
            state_d      = ST_FF0;
          end
        end
      end
      ST_FB2: begin
        if (mac_sts.done) begin
          mac_cmd.start = 1'b1;
          mac_cmd.load  = 1'b1;
          mac_coef      = coef.ff0;
          mac_operand   = acc;
          w_en          = 1'b1;
          state_d       = ST_FF0;
        end
      end
      ST_FF0: begin
        if (mac_sts.done) begin
          mac_cmd.start = 1'b1;
          mac_coef      = coef.ff1;
          mac_operand   = d1_q;
          state_d       = ST_FF1;
        end
      end
      ST_FF1: begin
        if (mac_sts.done) begin
          if (Order2) begin
            mac_cmd.start = 1'b1;
            mac_coef      = coef.ff2;
            mac_operand   = d2_q;
            state_d       = ST_FF2;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_FF2: begin
        if (mac_sts.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      d1_q        <= '0;
      d2_q        <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
        d1_q        <= w_q;
        if (Order2) begin
          d2_q <= d1_q;
        end
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_en) begin
      w_q <= acc;
    end
    if (out_load) begin
      out_q <= acc;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.sample_out = out_q;

  `IIR_DF2_ASSERT(a_out_from_done, clk_i, rst_ni,
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
  `IIR_DF2_ASSERT(a_no_start_busy, clk_i, rst_ni, mac_cmd.start |-> !mac_sts.busy)
  `IIR_DF2_ASSERT_NEVER(a_done_when_idle, clk_i, rst_ni,
    mac_sts.done && (state_q == ST_IDLE || state_q == ST_DONE))
  `IIR_DF2_ASSERT(a_delay_hold, clk_i, rst_ni, !out_load |=> $stable(d1_q))

endmodule

`default_nettype wire

// ===== rtl/iir_df2_cfg.sv =====
// APB coefficient register file
`default_nettype none

module iir_df2_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [iir_df2_pkg::APB_AW-1:0]    paddr,
  input  wire logic [iir_df2_pkg::APB_DW-1:0]    pwdata,
  output logic      [iir_df2_pkg::APB_DW-1:0]    prdata,
  output logic                                   pready,
  output iir_df2_pkg::coef_t                     coef_o
);

  localparam int unsigned PadW = iir_df2_pkg::APB_DW - iir_df2_pkg::DATA_W;

  iir_df2_pkg::coef_t                        coef_q;
  logic [iir_df2_pkg::REG_IDXW-1:0]          idx;
  logic [iir_df2_pkg::DATA_W-1:0]            wdata;
  logic                                      wr_en;

  assign idx    = paddr[iir_df2_pkg::APB_AW-1:2];
  assign wdata  = pwdata[iir_df2_pkg::DATA_W-1:0];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign coef_o = coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (wr_en) begin
      case (idx)
        iir_df2_pkg::REG_FB1: coef_q.fb1 <= wdata;
        iir_df2_pkg::REG_FB2: coef_q.fb2 <= wdata;
        iir_df2_pkg::REG_FF0: coef_q.ff0 <= wdata;
        iir_df2_pkg::REG_FF1: coef_q.ff1 <= wdata;
        iir_df2_pkg::REG_FF2: coef_q.ff2 <= wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      iir_df2_pkg::REG_FB1: prdata = {{PadW{1'b0}}, coef_q.fb1};
      iir_df2_pkg::REG_FB2: prdata = {{PadW{1'b0}}, coef_q.fb2};
      iir_df2_pkg::REG_FF0: prdata = {{PadW{1'b0}}, coef_q.ff0};
      iir_df2_pkg::REG_FF1: prdata = {{PadW{1'b0}}, coef_q.ff1};
      iir_df2_pkg::REG_FF2: prdata = {{PadW{1'b0}}, coef_q.ff2};
      default:              prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/iir_df2_mac.sv =====
// Digit-serial multiply-accumulate unit, products wrap to DATA_W bits
`default_nettype none
`include "iir_direct_form_two_filter_core_macros.svh"

module iir_df2_mac #(
  parameter int unsigned DIGIT_W = 4
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire iir_df2_pkg::mac_cmd_t           cmd_i,
  input  wire logic [iir_df2_pkg::DATA_W-1:0]  coef_i,
  input  wire logic [iir_df2_pkg::DATA_W-1:0]  operand_i,
  output iir_df2_pkg::mac_sts_t                sts_o,
  output logic      [iir_df2_pkg::DATA_W-1:0]  acc_o
);

  localparam int unsigned DataW     = iir_df2_pkg::DATA_W;
  localparam int unsigned NumDigits = DataW / DIGIT_W;
  localparam int unsigned CntW      = (NumDigits > 1) ? $clog2(NumDigits) : 1;
  localparam logic [CntW-1:0] LastDigit = CntW'(NumDigits - 1);

  logic                       busy_q;
  logic                       done_q;
  logic [CntW-1:0]            cnt_q;
  logic                       sub_q;
  logic [DataW-1:0]           acc_q;
  logic [DataW-1:0]           mcand_q;
  logic [DataW-1:0]           mplier_q;

  logic [DIGIT_W-1:0]         digit;
  logic [DataW+DIGIT_W-1:0]   prod_full;
  logic [DataW-1:0]           partial;
  logic [DataW-1:0]           acc_d;

  // multiplier digits go low first, multiplicand moves up one digit a step
  always_comb begin
    digit     = mplier_q[DIGIT_W-1:0];
    prod_full = mcand_q * digit;
    partial   = prod_full[DataW-1:0];
    acc_d     = sub_q ? (acc_q - partial) : (acc_q + partial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LastDigit) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mcand_q  <= coef_i;
      mplier_q <= operand_i;
      sub_q    <= cmd_i.sub;
      if (cmd_i.load) begin
        acc_q <= cmd_i.base;
      end
    end else if (busy_q) begin
      acc_q    <= acc_d;
      mcand_q  <= mcand_q << DIGIT_W;
      mplier_q <= mplier_q >> DIGIT_W;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign acc_o      = acc_q;

  `IIR_DF2_ASSERT(a_start_runs, clk_i, rst_ni, cmd_i.start |=> busy_q)
  `IIR_DF2_ASSERT(a_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q))
  `IIR_DF2_ASSERT_NEVER(a_busy_and_done, clk_i, rst_ni, busy_q && done_q)

endmodule

`default_nettype wire
